/* src/fst_pkg.sv */
// ----------------------------------------------------------------------------
// fst_pkg: shared definitions for the file slot table
// Sizes, result kinds, opcodes and the control bundle broadcast to the cells.
// ----------------------------------------------------------------------------
`default_nettype none

package fst_pkg;

    // table geometry
    localparam int SLOTS = 32;
    localparam int NAME_W = 31;
    localparam int DC_W = 6;
    localparam int KIND_W = 3;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int IDX_W = $clog2(SLOTS);
    localparam int CMP_W = (CNT_W > DC_W) ? CNT_W : DC_W;

    // stream widths
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;
    localparam int M_PAD_W = M_TDATA_W - KIND_W - NAME_W;

    // opcodes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_STORED = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FOUND = 3'd1;
    localparam logic [KIND_W-1:0] KIND_NOT_FOUND = 3'd2;
    localparam logic [KIND_W-1:0] KIND_EVICTED = 3'd3;
    localparam logic [KIND_W-1:0] KIND_EMPTY_EVICT = 3'd4;
    localparam logic [KIND_W-1:0] KIND_REJECTED = 3'd5;

    // control broadcast to every cell
    typedef struct packed {
        logic store_en;
        logic shift_en;
        logic [NAME_W-1:0] key;
    } cell_ctl_t;

endpackage

`default_nettype wire

/* src/fst_cell.sv */
// ----------------------------------------------------------------------------
// fst_cell: one slot of the table
// Holds one name (zero means empty), claims an insert when it is the lowest
// empty slot, compares against the search key and passes its name down the row.
// ----------------------------------------------------------------------------
`default_nettype none

module fst_cell
    import fst_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cell_ctl_t         ctl,
    input  wire logic              take_in,
    output logic                   take_out,
    input  wire logic [NAME_W-1:0] shift_in,
    output logic [NAME_W-1:0]      name_out,
    output logic                   match
);

    logic [NAME_W-1:0] name_reg, name_next;
    logic              empty;

    assign empty    = (name_reg == '0);
    // insert token keeps moving while this slot is occupied
    assign take_out = take_in && !empty;
    assign match    = (name_reg == ctl.key);
    assign name_out = name_reg;

    // rotate has priority, it never overlaps an insert
    always_comb begin
        name_next = name_reg;
        if (ctl.shift_en) begin
            name_next = shift_in;
        end else if (ctl.store_en && take_in && empty) begin
            name_next = ctl.key;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            name_reg <= '0;
        end else begin
            name_reg <= name_next;
        end
    end

endmodule

`default_nettype wire

/* src/file_slot_table.sv */
// Insert, search, reject and empty evict answer in the cycle after the transfer.
// Throughput: those take one item per cycle while the output is free; an evicting
// insert holds the input for one full rotation of the cell row, emitting one evicted
// name per cycle. Eviction output stalls follow the output channel's tready.
// Reset: synchronous active-low aresetn empties every slot and clears the count.
// ----------------------------------------------------------------------------
// file_slot_table: fixed table of file name slots
// Row of slot cells with insert, search and evict-when-full over a stream port.
// ----------------------------------------------------------------------------
`default_nettype none

module file_slot_table
    import fst_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [0] opcode, [31:1] file_name, [37:32] delete_count, [39:38] zero
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [2:0] result_kind, [33:3] result_name, [39:34] zero
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic                      m_tlast
);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_EVICT = 1'b1;

    logic              state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  evict_left_reg, evict_left_next;
    logic [IDX_W-1:0]  rot_reg, rot_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic              m_tlast_reg, m_tlast_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [NAME_W-1:0] rname_reg, rname_next;

    logic              in_acc, in_op, out_free, table_full, evicting, step, match_any;
    logic [NAME_W-1:0] in_name, wrap_name;
    logic [DC_W-1:0]   in_dc;
    logic [CNT_W-1:0]  dc_clamp;
    cell_ctl_t         cell_ctl;

    logic [NAME_W-1:0] name_vec [SLOTS];
    logic [SLOTS-1:0]  take_chain;
    logic [SLOTS-1:0]  match_vec;
    logic [SLOTS-1:0]  occ_vec;

    // input unpacking and handshake
    assign in_op    = s_tdata[0];
    assign in_name  = s_tdata[NAME_W:1];
    assign in_dc    = s_tdata[NAME_W+DC_W:NAME_W+1];
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign in_acc   = s_tvalid && s_tready;

    assign table_full = (count_reg == CNT_W'(SLOTS));
    assign evicting   = (evict_left_reg != '0);
    assign step       = (state_reg == ST_EVICT) && (!evicting || out_free);
    assign match_any  = |match_vec;

    // clamp delete count to the occupancy, which is SLOTS when full
    always_comb begin
        if (CMP_W'(in_dc) > CMP_W'(SLOTS)) begin
            dc_clamp = CNT_W'(SLOTS);
        end else begin
            dc_clamp = CNT_W'(in_dc);
        end
    end

    // cell control broadcast
    assign cell_ctl.store_en = in_acc && (in_name != '0) && (in_op == OP_INSERT) && !table_full;
    assign cell_ctl.shift_en = step;
    assign cell_ctl.key      = in_name;

    // the tail cell takes zero while evicting, otherwise the head wraps around
    assign wrap_name     = evicting ? '0 : name_vec[0];
    assign take_chain[0] = 1'b1;

    // row of slot cells
    for (genvar j = 0; j < SLOTS; j++) begin : g_cell
        assign occ_vec[j] = (name_vec[j] != '0);
        if (j == SLOTS - 1) begin : g_tail
            fst_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctl      (cell_ctl),
                .take_in  (take_chain[j]),
                .take_out (),
                .shift_in (wrap_name),
                .name_out (name_vec[j]),
                .match    (match_vec[j])
            );
        end else begin : g_body
            fst_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctl      (cell_ctl),
                .take_in  (take_chain[j]),
                .take_out (take_chain[j+1]),
                .shift_in (name_vec[j+1]),
                .name_out (name_vec[j]),
                .match    (match_vec[j])
            );
        end
    end

    // control and output register next state
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        evict_left_next = evict_left_reg;
        rot_next        = rot_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tlast_next    = m_tlast_reg;
        kind_next       = kind_reg;
        rname_next      = rname_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    rname_next   = '0;
                    m_tlast_next = 1'b1;
                    priority if (in_name == '0) begin
                        m_tvalid_next = 1'b1;
                        kind_next     = KIND_REJECTED;
                    end else if (in_op == OP_SEARCH) begin
                        m_tvalid_next = 1'b1;
                        kind_next     = match_any ? KIND_FOUND : KIND_NOT_FOUND;
                    end else if (!table_full) begin
                        m_tvalid_next = 1'b1;
                        kind_next     = KIND_STORED;
                        count_next    = count_reg + 1'b1;
                    end else if (dc_clamp == '0) begin
                        m_tvalid_next = 1'b1;
                        kind_next     = KIND_EMPTY_EVICT;
                    end else begin
                        state_next      = ST_EVICT;
                        evict_left_next = dc_clamp;
                        rot_next        = '0;
                    end
                end
            end
            ST_EVICT: begin
                if (step) begin
                    if (evicting) begin
                        m_tvalid_next   = 1'b1;
                        kind_next       = KIND_EVICTED;
                        rname_next      = name_vec[0];
                        m_tlast_next    = (evict_left_reg == CNT_W'(1));
                        evict_left_next = evict_left_reg - 1'b1;
                        count_next      = count_reg - 1'b1;
                    end
                    rot_next = rot_reg + 1'b1;
                    if (rot_reg == IDX_W'(SLOTS - 1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            evict_left_reg <= '0;
            rot_reg        <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            evict_left_reg <= evict_left_next;
            rot_reg        <= rot_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        m_tlast_reg <= m_tlast_next;
        kind_reg    <= kind_next;
        rname_reg   <= rname_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, rname_reg, kind_reg};

    // occupancy count tracks the occupied cells whenever the row is at rest
    a_count_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> ($countones(occ_vec) == int'(count_reg)))
        else $error("occupancy count out of step with cells");

    // no input transfer during an eviction rotation
    a_no_accept_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EVICT) |-> !s_tready)
        else $error("input accepted during eviction");

    // eviction only starts from a full table
    a_evict_from_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ($rose(state_reg == ST_EVICT)) |-> $past(table_full))
        else $error("eviction started on a table with room");

    // the rotation ends with every requested eviction delivered
    a_evict_done: assert property (@(posedge aclk) disable iff (!aresetn)
        ($fell(state_reg == ST_EVICT)) |-> (evict_left_reg == '0))
        else $error("rotation ended with evictions pending");

endmodule

`default_nettype wire
